// File: sv/acfb_pkg.sv
`timescale 1ns / 1ps
package acfb_pkg;

  localparam int POS_W      = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BEEPER_EN   = 3'd0,
    REG_DISPLAY_EN  = 3'd1,
    REG_VERT_SWING  = 3'd2,
    REG_HORIZ_SWING = 3'd3,
    REG_VERT_FIX    = 3'd4,
    REG_HORIZ_FIX   = 3'd5
  } cfg_idx_t;

  localparam logic [2:0] OPM_AUTO = 3'd1;
  localparam logic [2:0] OPM_COOL = 3'd2;
  localparam logic [2:0] OPM_DRY  = 3'd3;
  localparam logic [2:0] OPM_FAN  = 3'd4;
  localparam logic [2:0] OPM_HEAT = 3'd5;

  localparam logic [2:0] FAN_LOW        = 3'd1;
  localparam logic [2:0] FAN_MEDIUM     = 3'd2;
  localparam logic [2:0] FAN_HIGH       = 3'd3;
  localparam logic [2:0] FAN_LOW_MED    = 3'd4;
  localparam logic [2:0] FAN_MED_HIGH   = 3'd5;
  localparam logic [2:0] FAN_SILENT     = 3'd6;
  localparam logic [2:0] FAN_BOOST      = 3'd7;

  localparam logic [1:0] PRESET_ECO     = 2'd1;
  localparam logic [1:0] PRESET_SLEEP   = 2'd2;
  localparam logic [1:0] PRESET_COMFORT = 2'd3;

  localparam logic [2:0] FIX_MAX   = 3'd5;
  localparam logic [1:0] VPAT_MAX  = 2'd2;
  localparam logic [5:0] TEMP_MIN  = 6'd16;
  localparam logic [5:0] TEMP_MAX  = 6'd31;

  typedef struct packed {
    logic [1:0] preset;
    logic [1:0] swing;
    logic [2:0] fan;
    logic [3:0] temp_off;   // target - 16
    logic [2:0] mode;
  } req_t;

  typedef struct packed {
    logic       beep;
    logic       disp;
    logic [1:0] vert_pat;
    logic [1:0] horiz_pat;
    logic [2:0] vert_fix;
    logic [2:0] horiz_fix;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] frame_byte_f(input logic [POS_W-1:0] pos,
                                              input req_t r, input cfg_t c);
    logic       on;
    logic [7:0] b;
    on = (r.mode == OPM_AUTO) || (r.mode == OPM_COOL) || (r.mode == OPM_DRY) ||
         (r.mode == OPM_FAN) || (r.mode == OPM_HEAT);
    b  = 8'h00;
    case (pos)
      6'd0: b = 8'hBB;
      6'd2: b = 8'h01;
      6'd3: b = 8'h03;
      6'd4: b = 8'h20;
      6'd5: b = 8'h03;
      6'd6: b = 8'h01;
      6'd7: begin
        if (c.beep) b = b | 8'h20;
        if (c.disp && on) b = b | 8'h40;
        if (on) b = b | 8'h04;
        if (r.preset == PRESET_ECO) b = b | 8'h80;
      end
      6'd8: begin
        case (r.mode)
          OPM_AUTO: b = 8'h08;
          OPM_COOL: b = 8'h03;
          OPM_DRY:  b = 8'h02;
          OPM_FAN:  b = 8'h07;
          OPM_HEAT: b = 8'h01;
          default:  b = 8'h00;
        endcase
        if (r.fan == FAN_SILENT) b = b | 8'h80;
        if (r.fan == FAN_BOOST) b = b | 8'h40;
        if (r.preset == PRESET_COMFORT) b = b | 8'h10;
      end
      6'd9: b = {4'h0, ~r.temp_off};   // 31 - target
      6'd10: begin
        case (r.fan)
          FAN_LOW:      b = 8'h01;
          FAN_MEDIUM:   b = 8'h03;
          FAN_HIGH:     b = 8'h05;
          FAN_LOW_MED:  b = 8'h06;
          FAN_MED_HIGH: b = 8'h07;
          default:      b = 8'h00;
        endcase
        if (r.swing[0]) b = b | 8'h38;
      end
      6'd11: if (r.swing[1]) b = 8'h08;
      6'd13: b = 8'h01;
      6'd19: if (r.preset == PRESET_SLEEP) b = 8'h01;
      6'd32: begin
        if (c.vert_pat <= VPAT_MAX) b = {3'b000, c.vert_pat + 2'd1, 3'b000};
        if (c.vert_fix <= FIX_MAX) b = b | {5'd0, c.vert_fix};
      end
      6'd33: begin
        b = {2'b00, {1'b0, c.horiz_pat} + 3'd1, 3'b000};
        if (c.horiz_fix <= FIX_MAX) b = b | {5'd0, c.horiz_fix};
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/acfb_front.sv
`timescale 1ns / 1ps
module acfb_front (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // op_mode, target_degrees, fan, swing, preset
  output logic                 push_valid,
  output acfb_pkg::req_t       push_req,
  input  acfb_pkg::q_status_t  q_status
);
  import acfb_pkg::*;

  logic [5:0] temp_in;
  logic [3:0] temp_off;

  assign temp_in = in_tdata[8:3];

  // saturate target to 16..31 and keep the offset only
  always_comb begin
    if (temp_in < TEMP_MIN) begin
      temp_off = 4'd0;
    end else if (temp_in > TEMP_MAX) begin
      temp_off = 4'd15;
    end else begin
      temp_off = temp_in[3:0];
    end
  end

  assign in_tready       = !q_status.full;
  assign push_valid      = in_tvalid && !q_status.full;
  assign push_req.mode     = in_tdata[2:0];
  assign push_req.temp_off = temp_off;
  assign push_req.fan      = in_tdata[11:9];
  assign push_req.swing    = in_tdata[13:12];
  assign push_req.preset   = in_tdata[15:14];

endmodule

// File: sv/acfb_queue.sv
`timescale 1ns / 1ps
module acfb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  acfb_pkg::req_t       push_req,
  input  logic                 pop,
  output acfb_pkg::req_t       pop_req,
  output acfb_pkg::q_status_t  q_status
);
  import acfb_pkg::*;

  req_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_status.full  = (cnt_r == 2'd2);
  assign q_status.empty = (cnt_r == 2'd0);
  assign do_push = push_valid && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign pop_req = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// File: sv/acfb_back.sv
`timescale 1ns / 1ps
module acfb_back #(
  parameter int FRAME_BYTES = 38
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acfb_pkg::cfg_t       cfg,
  input  acfb_pkg::req_t       pop_req,
  input  acfb_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // frame_byte, byte_position, zero pad
  output logic                 out_tlast   // frame_end
);
  import acfb_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic             busy_r, busy_nxt;
  req_t             req_r, req_nxt;
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic [POS_W-1:0] opos_r, opos_nxt;
  logic             olast_r, olast_nxt;
  logic             issue, at_last;
  logic [7:0]       cur_byte;

  assign issue    = busy_r && (!ov_r || out_tready);
  assign at_last  = (cnt_r == LAST_POS);
  assign cur_byte = at_last ? xor_r : frame_byte_f(cnt_r, req_r, cfg);
  // take the next request as the last byte of this one goes out
  assign pop      = !q_status.empty && (!busy_r || (issue && at_last));

  always_comb begin
    busy_nxt  = busy_r;
    req_nxt   = req_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    ov_nxt    = ov_r && !out_tready;
    ob_nxt    = ob_r;
    opos_nxt  = opos_r;
    olast_nxt = olast_r;
    if (issue) begin
      ov_nxt    = 1'b1;
      ob_nxt    = cur_byte;
      opos_nxt  = cnt_r;
      olast_nxt = at_last;
      cnt_nxt   = cnt_r + POS_W'(1);
      xor_nxt   = xor_r ^ cur_byte;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      req_nxt  = pop_req;
      cnt_nxt  = '0;
      xor_nxt  = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      cnt_r  <= '0;
      xor_r  <= 8'h00;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      cnt_r  <= cnt_nxt;
      xor_r  <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    ob_r    <= ob_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(16 - 8 - POS_W){1'b0}}, opos_r, ob_r};
  assign out_tlast  = olast_r;

endmodule

// File: sv/ac_control_frame_builder_unit.sv
`timescale 1ns / 1ps
// Builds the UART control frame for a split air conditioner. Each request on
// the in_ channel (mode, target, fan, swing, preset) yields FRAME_BYTES result
// bytes on the out_ channel, header first and XOR checksum last with tlast
// set. The back-end sequencer emits one byte per clock unless out_tready holds
// it back; frames follow one another with no gap while requests are queued.
// A two-entry request queue sits between the input and the sequencer, so
// up to two requests are taken while a frame is still going out. Louver,
// beeper and display settings come from the cfg_ write port and apply to
// every frame built while they hold.
module ac_control_frame_builder_unit #(
  parameter int FRAME_BYTES = 38
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // op_mode[2:0], target_degrees[8:3],
                                                      // fan_setting[11:9], swing_setting[13:12],
                                                      // preset_setting[15:14]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // frame_byte[7:0], byte_position[13:8]
  output logic                            out_tlast,  // frame_end
  input  logic                            cfg_we,
  input  logic [acfb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [acfb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import acfb_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      push_valid;
  req_t      push_req;
  req_t      pop_req;
  logic      pop;
  q_status_t q_status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_BEEPER_EN:   cfg_nxt.beep      = cfg_wdata[0];
        REG_DISPLAY_EN:  cfg_nxt.disp      = cfg_wdata[0];
        REG_VERT_SWING:  cfg_nxt.vert_pat  = cfg_wdata[1:0];
        REG_HORIZ_SWING: cfg_nxt.horiz_pat = cfg_wdata[1:0];
        REG_VERT_FIX:    cfg_nxt.vert_fix  = cfg_wdata;
        REG_HORIZ_FIX:   cfg_nxt.horiz_fix = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  acfb_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_req   (push_req),
    .q_status   (q_status)
  );

  acfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_req   (push_req),
    .pop        (pop),
    .pop_req    (pop_req),
    .q_status   (q_status)
  );

  acfb_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_req    (pop_req),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // tlast marks exactly the checksum position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[13:8] == 6'(FRAME_BYTES - 1))))
    else $error("tlast does not match last byte position");

  // output stream never goes idle mid-frame
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (out_tdata[13:8] == 6'd0))
    else $error("output resumed in the middle of a frame");

  // a completed frame ends on the checksum byte position, never past it
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[13:8] <= 6'(FRAME_BYTES - 1)))
    else $error("byte position beyond frame length");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import acfb_pkg::*;

  localparam int FRAME_LEN   = 38;
  localparam int STALL_LIMIT = 2000;

  localparam logic [2:0] OPM_OFF     = 3'd0;
  localparam logic [2:0] FAN_AUTO    = 3'd0;
  localparam logic [1:0] PRESET_NONE = 2'd0;
  localparam logic [1:0] SWG_NONE    = 2'd0;
  localparam logic [1:0] SWG_VH      = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       last;
  } frame_octet_t;

  typedef struct packed {
    logic       beep;
    logic       disp;
    logic [1:0] vpat;
    logic [1:0] hpat;
    logic [2:0] vfix;
    logic [2:0] hfix;
  } panel_cfg_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frame_octet_t frame_q[$];
  frame_octet_t due_octet;
  panel_cfg_t   panel;
  bit           steady;
  int           err_count = 0;
  int           quiet_cycles = 0;

  ac_control_frame_builder_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [15:0] pack_request(input logic [2:0] mode, input logic [5:0] tdeg,
                                               input logic [2:0] fan, input logic [1:0] swing,
                                               input logic [1:0] preset);
    return {preset, swing, fan, tdeg, mode};
  endfunction

  // Expected frame bytes for one request under the current panel settings
  function automatic void predict_frame(input logic [15:0] word);
    logic [7:0]   fb [FRAME_LEN];
    logic [2:0]   mode;
    logic [5:0]   tdeg;
    logic [2:0]   fan;
    logic [1:0]   swing;
    logic [1:0]   preset;
    logic         on;
    logic [7:0]   sum;
    frame_octet_t oct;
    int           i;
    mode   = word[2:0];
    tdeg   = word[8:3];
    fan    = word[11:9];
    swing  = word[13:12];
    preset = word[15:14];
    for (i = 0; i < FRAME_LEN; i++) fb[i] = 8'h00;
    fb[0]  = 8'hBB;
    fb[2]  = 8'h01;
    fb[3]  = 8'h03;
    fb[4]  = 8'h20;
    fb[5]  = 8'h03;
    fb[6]  = 8'h01;
    fb[13] = 8'h01;

    if (tdeg < TEMP_MIN) tdeg = TEMP_MIN;
    else if (tdeg > TEMP_MAX) tdeg = TEMP_MAX;
    fb[9] = {2'b00, TEMP_MAX - tdeg};

    on = (mode >= OPM_AUTO) && (mode <= OPM_HEAT);
    if (panel.beep) fb[7] |= 8'h20;
    if (panel.disp && on) fb[7] |= 8'h40;
    if (on) fb[7] |= 8'h04;

    case (mode)
      OPM_AUTO: fb[8] = 8'h08;
      OPM_COOL: fb[8] = 8'h03;
      OPM_DRY:  fb[8] = 8'h02;
      OPM_FAN:  fb[8] = 8'h07;
      OPM_HEAT: fb[8] = 8'h01;
      default:  fb[8] = 8'h00;
    endcase

    // silent and power ride in byte 8 and leave the speed byte clear
    case (fan)
      FAN_SILENT:   fb[8] |= 8'h80;
      FAN_BOOST:    fb[8] |= 8'h40;
      FAN_LOW:      fb[10] = 8'h01;
      FAN_MEDIUM:   fb[10] = 8'h03;
      FAN_HIGH:     fb[10] = 8'h05;
      FAN_LOW_MED:  fb[10] = 8'h06;
      FAN_MED_HIGH: fb[10] = 8'h07;
      default:      fb[10] = 8'h00;
    endcase
    if (swing[0]) fb[10] |= 8'h38;
    if (swing[1]) fb[11] |= 8'h08;

    case (preset)
      PRESET_ECO:     fb[7] |= 8'h80;
      PRESET_SLEEP:   fb[19] |= 8'h01;
      PRESET_COMFORT: fb[8] |= 8'h10;
      default:        ;
    endcase

    if (panel.vpat <= VPAT_MAX) fb[32] |= ({6'd0, panel.vpat} + 8'd1) << 3;
    fb[33] |= ({6'd0, panel.hpat} + 8'd1) << 3;
    if (panel.vfix <= FIX_MAX) fb[32] |= {5'd0, panel.vfix};
    if (panel.hfix <= FIX_MAX) fb[33] |= {5'd0, panel.hfix};

    sum = 8'h00;
    for (i = 0; i < FRAME_LEN - 1; i++) begin
      sum ^= fb[i];
      oct = '{data: fb[i], pos: i[5:0], last: 1'b0};
      frame_q.insert(frame_q.size(), oct);
    end
    oct = '{data: sum, pos: 6'(FRAME_LEN - 1), last: 1'b1};
    frame_q.insert(frame_q.size(), oct);
  endfunction

  task automatic send_request(input logic [15:0] word);
    if (!steady) begin
      while ($urandom_range(99) < 14) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    predict_frame(word);
  endtask

  task automatic wait_for_frames();
    in_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [2:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Full 3-bit values go out on every register; the unit keeps only the low bits of the enable and pattern registers
  task automatic apply_settings(input logic [2:0] beep_v, input logic [2:0] disp_v,
                                input logic [2:0] vpat_v, input logic [2:0] hpat_v,
                                input logic [2:0] vfix_v, input logic [2:0] hfix_v);
    wait_for_frames();
    write_reg(REG_BEEPER_EN, beep_v);
    write_reg(REG_DISPLAY_EN, disp_v);
    write_reg(REG_VERT_SWING, vpat_v);
    write_reg(REG_HORIZ_SWING, hpat_v);
    write_reg(REG_VERT_FIX, vfix_v);
    write_reg(REG_HORIZ_FIX, hfix_v);
    cfg_we     <= 1'b0;
    panel.beep = beep_v[0];
    panel.disp = disp_v[0];
    panel.vpat = vpat_v[1:0];
    panel.hpat = hpat_v[1:0];
    panel.vfix = vfix_v;
    panel.hfix = hfix_v;
  endtask

  task automatic apply_random_settings();
    apply_settings(3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                   3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)));
  endtask

  function automatic logic [15:0] random_request();
    logic [15:0] word;
    word = 16'($urandom);
    if ($urandom_range(1)) word[8:3] = 6'($urandom_range(TEMP_MAX, TEMP_MIN));
    return word;
  endfunction

  // Every mode, fan level, swing and preset, plus the temperature edges
  task automatic test_field_extremes();
    logic [5:0] temps [8];
    int         i;
    temps = '{6'd0, 6'd15, 6'd16, 6'd17, 6'd30, 6'd31, 6'd32, 6'd63};
    apply_settings(3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0);
    for (i = 0; i < 8; i++) begin
      send_request(pack_request(i[2:0], temps[i], 3'(7 - i), i[1:0], 2'(i + 1)));
    end
    send_request(pack_request(OPM_HEAT, 6'd63, FAN_BOOST, SWG_VH, PRESET_COMFORT));
    send_request(pack_request(OPM_OFF, 6'd0, FAN_AUTO, SWG_NONE, PRESET_NONE));
    send_request(16'hFFFF);
    send_request(pack_request(OPM_AUTO, 6'd0, FAN_SILENT, SWG_NONE, PRESET_SLEEP));
    wait_for_frames();
  endtask

  task automatic test_config_settings();
    apply_settings(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
    send_request(random_request());
    send_request(random_request());
    apply_settings(3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7);
    send_request(random_request());
    send_request(random_request());
    apply_settings(3'd1, 3'd1, {1'b0, VPAT_MAX}, 3'd3, FIX_MAX, FIX_MAX);
    send_request(random_request());
    send_request(pack_request(OPM_OFF, 6'd20, FAN_HIGH, SWG_VH, PRESET_ECO));
    // vertical pattern three and fixation code six contribute nothing
    apply_settings(3'd0, 3'd1, 3'd3, 3'd0, 3'd6, 3'd6);
    send_request(random_request());
    send_request(random_request());
    apply_settings(3'd2, 3'd2, 3'd5, 3'd6, 3'd1, 3'd2);
    send_request(random_request());
    send_request(random_request());
    wait_for_frames();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    apply_random_settings();
    repeat (60) send_request(random_request());
    wait_for_frames();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    for (phase = 0; phase < 6; phase++) begin
      apply_random_settings();
      for (n = 0; n < 70; n++) begin
        // hold requests back until the unit has flushed everything once
        if (phase == 2 && n == 35) wait_for_frames();
        send_request(random_request());
      end
    end
    wait_for_frames();
  endtask

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected frame byte: expected none, actual tdata %h tlast %b",
                 $time, out_tdata, out_tlast);
        err_count++;
      end else begin
        due_octet = frame_q.pop_front();
        if (out_tdata[7:0] !== due_octet.data) begin
          $display("%0t: frame_byte mismatch at pos %0d: expected %h actual %h",
                   $time, due_octet.pos, due_octet.data, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[13:8] !== due_octet.pos) begin
          $display("%0t: byte_position mismatch: expected %0d actual %0d",
                   $time, due_octet.pos, out_tdata[13:8]);
          err_count++;
        end
        if (out_tlast !== due_octet.last) begin
          $display("%0t: frame_end mismatch at pos %0d: expected %b actual %b",
                   $time, due_octet.pos, due_octet.last, out_tlast);
          err_count++;
        end
        if (out_tdata[15:14] !== 2'b00) begin
          $display("%0t: tdata pad mismatch: expected 00 actual %b", $time, out_tdata[15:14]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d bytes outstanding",
               $time, quiet_cycles, frame_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    steady       = 1'b0;
    panel        = '0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_BEEPER_EN;
    cfg_wdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_config_settings();
    test_back_to_back();
    test_random_traffic();

    wait_for_frames();
    repeat (2 * FRAME_LEN) @(posedge clk);
    if (err_count == 0 && frame_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: ac_control_frame_builder_unit.f
sv/acfb_pkg.sv
sv/acfb_front.sv
sv/acfb_queue.sv
sv/acfb_back.sv
sv/ac_control_frame_builder_unit.sv
verif/tb.sv
